[hw/rtl/aesctr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_pkg: shared types, constants and functions for the AES-128 CTR block
// S-box, GF(2^8) doubling and the round functions used by several modules.
// ----------------------------------------------------------------------------
package aesctr_pkg;

  localparam int NumRounds = 10;
  localparam int RkWords   = 44;
  localparam logic [7:0] PolyLow = 8'h1b;

  localparam logic [1:0] CFG_KEY_UPPER   = 2'd0;
  localparam logic [1:0] CFG_KEY_LOWER   = 2'd1;
  localparam logic [1:0] CFG_NONCE_UPPER = 2'd2;
  localparam logic [1:0] CFG_NONCE_LOWER = 2'd3;

  typedef logic [127:0] state_t;

  typedef struct packed {
    logic [63:0] data_upper;
    logic [63:0] data_lower;
    logic [4:0]  count;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    case (x)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? PolyLow : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic state_t sub_shift(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic state_t mix_columns(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

[hw/rtl/aes128_ctr_keystream_xor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_xor: AES-128 counter-mode keystream XOR
// Usage: write key and nonce registers through cfg_we/cfg_index/cfg_data while
// idle; the key schedule settles after a key write. Issue a block by
// raising start with block_counter, data and byte_count; busy is always low, so
// one beat is taken every cycle. Counter block = nonce || block_counter.
// The pipeline has 12 register stages: input/whitening, ten round stages
// (one AES round each) and the output stage that masks bytes past
// byte_count. Throughput is one block per cycle. done strobes for one cycle
// with result_upper/lower/count. Reset clears the nonce and key registers,
// the pipeline valid bits and done, and re-expands the all-zero key. The
// receiver cannot stall, so no beat is held.
// ----------------------------------------------------------------------------
module aes128_ctr_keystream_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] block_counter,
  input  logic [63:0] data_upper,
  input  logic [63:0] data_lower,
  input  logic [4:0]  byte_count,
  output logic        done,
  output logic [63:0] result_upper,
  output logic [63:0] result_lower,
  output logic [4:0]  result_count
);

  localparam int N = aesctr_pkg::NumRounds;

  logic [63:0]  nonce_upper;
  logic [31:0]  nonce_lower;
  logic [10:0][127:0] rkey;
  logic         key_we;

  logic               v   [0:N];
  aesctr_pkg::state_t st  [0:N];
  aesctr_pkg::side_t  sd  [0:N];

  assign busy   = 1'b0;
  assign key_we = cfg_we && (cfg_index == aesctr_pkg::CFG_KEY_UPPER ||
                             cfg_index == aesctr_pkg::CFG_KEY_LOWER);

  always_ff @(posedge clk) begin
    if (rst) begin
      nonce_upper <= '0;
      nonce_lower <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aesctr_pkg::CFG_NONCE_UPPER: nonce_upper <= cfg_data;
        aesctr_pkg::CFG_NONCE_LOWER: nonce_lower <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  aesctr_key_expand u_keys (
    .clk(clk), .rst(rst), .key_we(key_we),
    .key_sel_lower(cfg_index == aesctr_pkg::CFG_KEY_LOWER),
    .key_data(cfg_data), .rkey(rkey)
  );

  // stage 0: build counter block and whiten
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= start;
    end
    st[0] <= {nonce_upper, nonce_lower, block_counter} ^ rkey[0];
    sd[0] <= '{data_upper: data_upper, data_lower: data_lower, count: byte_count};
  end

  for (genvar r = 1; r <= N; r++) begin : g_round
    aesctr_round u_round (
      .clk(clk), .rst(rst), .last(r == N), .round_key(rkey[r]),
      .in_valid(v[r-1]), .in_state(st[r-1]), .in_side(sd[r-1]),
      .out_valid(v[r]), .out_state(st[r]), .out_side(sd[r])
    );
  end

  logic [127:0] mask;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8 * i -: 8] = (5'(i) < sd[N].count) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[N];
    end
    {result_upper, result_lower} <= ({sd[N].data_upper, sd[N].data_lower} ^ st[N]) & mask;
    result_count <= sd[N].count;
  end

  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    v[N] |=> done) else $error("lost beat at output");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    done && result_count == 5'd0 |-> result_upper == 64'h0 && result_lower == 64'h0)
    else $error("zero count gave data");

endmodule

[hw/rtl/aesctr_key_expand.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_key_expand: round-key register file
// Holds the key words and the 11 round keys; one round key per cycle is
// recomputed after a key write, from round key 1 up to round key 10.
// ----------------------------------------------------------------------------
module aesctr_key_expand (
  input  logic                clk,
  input  logic                rst,
  input  logic                key_we,
  input  logic                key_sel_lower,
  input  logic [63:0]         key_data,
  output logic [10:0][127:0]  rkey
);

  logic [127:0] key;
  logic [3:0]   step;
  logic         run;
  logic [7:0]   rcon;
  logic [127:0] prev;
  logic [31:0]  t, w0, w1, w2, w3;

  assign prev = rkey[step - 4'd1];
  assign t  = aesctr_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'h0};
  assign w0 = prev[127:96] ^ t;
  assign w1 = prev[95:64] ^ w0;
  assign w2 = prev[63:32] ^ w1;
  assign w3 = prev[31:0] ^ w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      key        <= '0;
      rkey       <= '0;
      run        <= 1'b1;
      step       <= 4'd1;
      rcon       <= 8'h01;
    end else if (key_we) begin
      if (key_sel_lower) begin
        key[63:0]     <= key_data;
        rkey[0][63:0] <= key_data;
      end else begin
        key[127:64]     <= key_data;
        rkey[0][127:64] <= key_data;
      end
      run  <= 1'b1;
      step <= 4'd1;
      rcon <= 8'h01;
    end else if (run) begin
      rkey[step] <= {w0, w1, w2, w3};
      rcon <= aesctr_pkg::gf_double(rcon);
      if (step == 4'(aesctr_pkg::NumRounds)) begin
        run <= 1'b0;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  a_key0: assert property (@(posedge clk) disable iff (rst)
    !run |-> rkey[0] == key) else $error("round key 0 differs from key");
  a_step: assert property (@(posedge clk) disable iff (rst)
    run |-> step >= 4'd1 && step <= 4'd10) else $error("key step out of range");
  a_done: assert property (@(posedge clk) disable iff (rst)
    run && !key_we && step == 4'd10 |=> !run) else $error("sweep did not end");

endmodule

[hw/rtl/aesctr_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_round: one registered AES round stage
// SubBytes/ShiftRows, optional MixColumns, AddRoundKey; side data rides along.
// ----------------------------------------------------------------------------
module aesctr_round (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  last,
  input  logic [127:0]          round_key,
  input  logic                  in_valid,
  input  aesctr_pkg::state_t    in_state,
  input  aesctr_pkg::side_t     in_side,
  output logic                  out_valid,
  output aesctr_pkg::state_t    out_state,
  output aesctr_pkg::side_t     out_side
);

  aesctr_pkg::state_t ss;
  assign ss = aesctr_pkg::sub_shift(in_state);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= (last ? ss : aesctr_pkg::mix_columns(ss)) ^ round_key;
    out_side  <= in_side;
  end

endmodule
